@@ rtl/sdc_pkg.sv @@
package sdc_pkg;

  // Largest modulus the histogram can serve.
  localparam int MaxMod = 1024;

  // Field widths.
  localparam int ValW   = 32;
  localparam int CfgModW = 11;
  localparam int TotW   = 48;
  localparam int CntW   = 32;

  // Residue and effective modulus widths follow from MaxMod.
  localparam int ResW   = (MaxMod > 1) ? $clog2(MaxMod) : 1;
  localparam int ModW   = $clog2(MaxMod + 1);
  localparam int StepW  = $clog2(ValW);

  // Register map: word index of the modulus register.
  localparam logic RegModulus = 1'b0;

  // Request to the remainder unit.
  typedef struct packed {
    logic            start;
    logic            neg;
    logic [ValW-1:0] mag;
  } mod_req_t;

  // Answer from the remainder unit.
  typedef struct packed {
    logic            done;
    logic [ResW-1:0] residue;
  } mod_res_t;

endpackage

@@ rtl/sdc_mod_unit.sv @@
module sdc_mod_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sdc_pkg::mod_req_t       req_i,
  input  logic [sdc_pkg::ModW-1:0] modulus_i,
  output sdc_pkg::mod_res_t       res_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_STEP,
    M_FIX
  } mstate_e;

  mstate_e                      state_q;
  logic [sdc_pkg::ValW-1:0]     dvd_q;
  logic [sdc_pkg::ResW-1:0]     rem_q;
  logic [sdc_pkg::StepW-1:0]    cnt_q;
  logic                         neg_q;
  logic                         done_q;
  logic [sdc_pkg::ResW-1:0]     res_q;

  logic [sdc_pkg::ResW:0]       trial;
  logic [sdc_pkg::ResW:0]       mod_ext;
  logic [sdc_pkg::ResW:0]       diff;
  logic [sdc_pkg::ResW-1:0]     rem_d;
  logic [sdc_pkg::ResW-1:0]     fixed;

  // Shared restoring step: shift in one dividend bit, subtract the modulus if it fits.
  always_comb begin
    mod_ext = (sdc_pkg::ResW + 1)'(modulus_i);
    trial   = {rem_q, dvd_q[sdc_pkg::ValW-1]};
    diff    = trial - mod_ext;
    if (trial >= mod_ext) begin
      rem_d = diff[sdc_pkg::ResW-1:0];
    end else begin
      rem_d = trial[sdc_pkg::ResW-1:0];
    end
  end

  // A negative sum maps a nonzero remainder to modulus minus remainder.
  always_comb begin
    logic [sdc_pkg::ResW:0] neg_rem;
    neg_rem = mod_ext - (sdc_pkg::ResW + 1)'(rem_q);
    if (neg_q && (rem_q != '0)) begin
      fixed = neg_rem[sdc_pkg::ResW-1:0];
    end else begin
      fixed = rem_q;
    end
  end

  // Sequencer: one dividend bit per cycle, then the sign correction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      dvd_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == M_FIX);
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            dvd_q   <= req_i.mag;
            neg_q   <= req_i.neg;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= M_STEP;
          end
        end
        M_STEP: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[sdc_pkg::ValW-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == sdc_pkg::StepW'(sdc_pkg::ValW - 1)) begin
            state_q <= M_FIX;
          end
        end
        M_FIX: begin
          res_q   <= fixed;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign res_o.done    = done_q;
  assign res_o.residue = res_q;

endmodule

@@ rtl/sdc_hist_ram.sv @@
module sdc_hist_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [sdc_pkg::ResW-1:0] waddr_i,
  input  logic [sdc_pkg::CntW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [sdc_pkg::ResW-1:0] raddr_i,
  output logic [sdc_pkg::CntW-1:0] rdata_o
);

  logic [sdc_pkg::CntW-1:0] mem [sdc_pkg::MaxMod];
  logic [sdc_pkg::CntW-1:0] rdata_q;

  // One write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/subarray_sum_divisible_counter.sv @@
// Counts contiguous subarrays whose sum is divisible by the programmed modulus.
// Input channel (in_valid_i/in_ready_o) carries a signed 32-bit value and a
// last marker; each accepted item yields one result item on the output channel
// (out_valid_o/out_ready_i): the running pair total, a sticky saturation flag
// and an echo of the last marker.
// The block takes one item at a time: the next item is accepted only after the
// previous one has left its update step. The remainder unit reduces the new
// prefix sum one dividend bit per cycle (32 steps plus a sign correction);
// then follow one histogram read and one update step.
// The 1024-entry histogram is swept (entry 0 to one, the rest to zero) after
// reset and after every item marked last; in_ready_o stays low during the sweep.
// The result sits in an output register; if the receiver stalls, the block
// holds it and waits in its update step without losing the item.
// The modulus is written over the APB port at address 0 (reset value 1) and
// must only be changed while the block is idle.
module subarray_sum_divisible_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [sdc_pkg::ValW-1:0]  value_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sdc_pkg::TotW-1:0]         pair_total_o,
  output logic                             saturated_o,
  output logic                             is_last_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_UPDATE
  } state_e;

  state_e                        state_q;
  logic [sdc_pkg::ResW-1:0]      clr_q;
  logic [sdc_pkg::ResW-1:0]      prefix_q;
  logic [sdc_pkg::TotW-1:0]      total_q;
  logic                          ovf_q;
  logic                          last_q;
  logic                          out_valid_q;
  logic [sdc_pkg::TotW-1:0]      out_total_q;
  logic                          out_sat_q;
  logic                          out_last_q;
  logic [sdc_pkg::CfgModW-1:0]   modulus_q;

  logic [sdc_pkg::ModW-1:0]      eff_mod;
  logic                          in_accept;
  logic signed [sdc_pkg::ValW:0] sum_s;
  logic [sdc_pkg::ValW:0]        mag_full;
  sdc_pkg::mod_req_t             mod_req;
  sdc_pkg::mod_res_t             mod_res;

  logic                          proceed;
  logic [sdc_pkg::CntW-1:0]      cnt;
  logic [sdc_pkg::TotW:0]        tot_sum;
  logic                          tot_over;
  logic                          cnt_full;
  logic                          mem_we;
  logic [sdc_pkg::ResW-1:0]      mem_waddr;
  logic [sdc_pkg::CntW-1:0]      mem_wdata;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= sdc_pkg::CfgModW'(1);
    end else if (psel && penable && pwrite && (paddr[2] == sdc_pkg::RegModulus)) begin
      modulus_q <= pwdata[sdc_pkg::CfgModW-1:0];
    end
  end

  assign prdata = (paddr[2] == sdc_pkg::RegModulus) ? 32'(modulus_q) : '0;

  // Zero acts as one, anything above the histogram size as the histogram size.
  always_comb begin
    if (modulus_q == '0) begin
      eff_mod = sdc_pkg::ModW'(1);
    end else if (32'(modulus_q) > sdc_pkg::MaxMod) begin
      eff_mod = sdc_pkg::ModW'(sdc_pkg::MaxMod);
    end else begin
      eff_mod = sdc_pkg::ModW'(modulus_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // New prefix sum before reduction; its residue equals the reduced prefix residue.
  assign sum_s    = (sdc_pkg::ValW + 1)'(value_i)
                  + $signed({{(sdc_pkg::ValW + 1 - sdc_pkg::ResW){1'b0}}, prefix_q});
  assign mag_full = sum_s[sdc_pkg::ValW] ? (~sum_s + 1'b1) : sum_s;

  assign mod_req.start = in_accept;
  assign mod_req.neg   = sum_s[sdc_pkg::ValW];
  assign mod_req.mag   = mag_full[sdc_pkg::ValW-1:0];

  sdc_mod_unit u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .modulus_i(eff_mod),
    .res_o    (mod_res)
  );

  // Update step: add the stored count to the total and bump the entry.
  assign proceed  = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign tot_sum  = {1'b0, total_q} + (sdc_pkg::TotW + 1)'(cnt);
  assign tot_over = tot_sum[sdc_pkg::TotW];
  assign cnt_full = (cnt == '1);

  // Histogram write port: clearing sweep or count update.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prefix_q;
    mem_wdata = cnt + 1'b1;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = (clr_q == '0) ? sdc_pkg::CntW'(1) : '0;
    end else if (proceed && !cnt_full) begin
      mem_we = 1'b1;
    end
  end

  sdc_hist_ram u_hist (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   ((state_q == S_MOD) && mod_res.done),
    .raddr_i(mod_res.residue),
    .rdata_o(cnt)
  );

  // Sequencer with the sequence state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      prefix_q    <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
      out_sat_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      // The output register refills from the update step and empties when taken.
      if (proceed) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == sdc_pkg::ResW'(sdc_pkg::MaxMod - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            last_q  <= last_i;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_res.done) begin
            prefix_q <= mod_res.residue;
            state_q  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (proceed) begin
            out_last_q  <= last_q;
            out_total_q <= tot_over ? '1 : tot_sum[sdc_pkg::TotW-1:0];
            out_sat_q   <= ovf_q || tot_over || cnt_full;
            if (last_q) begin
              total_q  <= '0;
              ovf_q    <= 1'b0;
              prefix_q <= '0;
              clr_q    <= '0;
              state_q  <= S_CLEAR;
            end else begin
              total_q <= tot_over ? '1 : tot_sum[sdc_pkg::TotW-1:0];
              ovf_q   <= ovf_q || tot_over || cnt_full;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pair_total_o = out_total_q;
  assign saturated_o  = out_sat_q;
  assign is_last_o    = out_last_q;

endmodule

@@ rtl/sdc_checker.sv @@
module sdc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [sdc_pkg::TotW-1:0]         pair_total_o,
  input logic                             saturated_o,
  input logic                             is_last_o,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [2:0]                       paddr,
  input logic [31:0]                      pwdata,
  input logic [31:0]                      prdata,
  input logic                             pready
);

  // A stalled result holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pair_total_o)
      && $stable(saturated_o) && $stable(is_last_o))
    else $error("stalled result item changed");

  // The remainder unit keeps the block busy after an item is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input accepted while previous item still in work");

  // The block is never ready while a result would be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || $stable(pair_total_o))
    else $error("result changed right after an item was accepted");

  // A modulus write reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == sdc_pkg::RegModulus)
      ##1 (paddr[2] == sdc_pkg::RegModulus)
      |-> prdata == 32'($past(pwdata[sdc_pkg::CfgModW-1:0])))
    else $error("modulus register readback mismatch");

endmodule

bind subarray_sum_divisible_counter sdc_checker u_sdc_checker (.*);

@@ sim/subarray_sum_divisible_checker.sv @@
// Watches the item channels and the register port of the divisible-subarray
// counter, keeps its own copy of the counter state, and checks every result.
module subarray_sum_divisible_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic signed [sdc_pkg::ValW-1:0] value_i,
  input  logic                            last_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [sdc_pkg::TotW-1:0]        pair_total_i,
  input  logic                            saturated_i,
  input  logic                            is_last_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [2:0]                      paddr_i,
  input  logic [31:0]                     pwdata_i,
  output int                              mismatches_o,
  output int                              pending_o
);

  import sdc_pkg::*;

  localparam longint TotalMax = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [TotW-1:0] pair_total;
    logic            saturated;
    logic            is_last;
  } tally_t;

  // Shadow copy of the counter state.
  logic [CfgModW-1:0] modulus_q;
  logic [ResW-1:0]    prefix_residue;
  logic [CntW-1:0]    residue_count [MaxMod];
  logic [TotW-1:0]    pair_total_q;
  logic               saturated_q;

  tally_t expected_tallies [$];
  tally_t oldest;

  int mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // Starts a fresh sequence: only the empty prefix has been seen.
  function automatic void restart_sequence();
    prefix_residue = '0;
    for (int i = 0; i < MaxMod; i++) residue_count[i] = '0;
    residue_count[0] = 1;
    pair_total_q = '0;
    saturated_q = 1'b0;
  endfunction

  // Folds one element into the shadow state and returns the result it causes.
  function automatic tally_t tally_item(logic signed [ValW-1:0] val, logic lst);
    tally_t t;
    longint m;
    longint vm;
    longint r;
    logic [CntW-1:0] cnt;
    // A zero modulus acts as one, and large ones clamp to the histogram size.
    if (modulus_q == 0) m = 1;
    else if (modulus_q > MaxMod) m = MaxMod;
    else m = longint'(modulus_q);
    vm = longint'(val) % m;
    if (vm < 0) vm += m;
    r = (longint'(prefix_residue) % m + vm) % m;
    prefix_residue = ResW'(r);
    cnt = residue_count[r];
    // Both the total and the histogram entries stick at their maximum.
    if (longint'(cnt) > TotalMax - longint'(pair_total_q)) begin
      pair_total_q = TotW'(TotalMax);
      saturated_q = 1'b1;
    end else begin
      pair_total_q = pair_total_q + TotW'(cnt);
    end
    if (cnt == '1) saturated_q = 1'b1;
    else residue_count[r] = cnt + 1'b1;
    t.pair_total = pair_total_q;
    t.saturated = saturated_q;
    t.is_last = lst;
    if (lst) restart_sequence();
    return t;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Results are checked before new items are predicted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q = CfgModW'(1);
      restart_sequence();
      expected_tallies.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          (paddr_i >> 2) == 3'(RegModulus)) begin
        modulus_q = pwdata_i[CfgModW-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_tallies.size() == 0) begin
          report_mismatch("result with no item outstanding", 64'(pair_total_i), 0);
        end else begin
          oldest = expected_tallies.pop_front();
          if (pair_total_i !== oldest.pair_total)
            report_mismatch("pair_total", 64'(pair_total_i), 64'(oldest.pair_total));
          if (saturated_i !== oldest.saturated)
            report_mismatch("saturated", 64'(saturated_i), 64'(oldest.saturated));
          if (is_last_i !== oldest.is_last)
            report_mismatch("is_last", 64'(is_last_i), 64'(oldest.is_last));
        end
      end
      if (in_valid_i && in_ready_i) expected_tallies.push_back(tally_item(value_i, last_i));
    end
    pending_o = expected_tallies.size();
  end

endmodule

@@ sim/tb_subarray_sum_divisible_counter.sv @@
module tb_subarray_sum_divisible_counter;

  import sdc_pkg::*;

  localparam logic [2:0] ModulusAddr  = {RegModulus, 2'b00};
  localparam logic [2:0] UnmappedAddr = 3'd4;
  localparam int ItemTarget   = 1650;
  localparam int SettleCycles = 40;
  localparam int QuietLimit   = 6000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [ValW-1:0] value_i = '0;
  logic                   last_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [TotW-1:0]        pair_total_o;
  logic                   saturated_o;
  logic                   is_last_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int mismatches;
  int pending;
  int items_sent = 0;
  int cur_mod = 1;
  int seq_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  subarray_sum_divisible_counter u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_i, .last_i,
    .out_valid_o, .out_ready_i, .pair_total_o, .saturated_o, .is_last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  subarray_sum_divisible_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .value_i, .last_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pair_total_i(pair_total_o), .saturated_i(saturated_o), .is_last_i(is_last_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls in short random bursts while stalls are enabled.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item, possibly after a short gap, and returns once it is taken.
  task automatic send_value(input logic signed [ValW-1:0] v, input logic l);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    last_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Lets every outstanding result arrive, then lets the block settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (addr == ModulusAddr) begin
      if (data[CfgModW-1:0] == 0) cur_mod = 1;
      else if (data[CfgModW-1:0] > MaxMod) cur_mod = MaxMod;
      else cur_mod = int'(data[CfgModW-1:0]);
    end
  endtask

  initial begin
    logic signed [ValW-1:0] v;
    logic [31:0] mod_word;
    bit idle_mode;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset modulus of one, every subarray counts.
    send_value(32'sh7fffffff, 1'b0);
    send_value(32'sh80000000, 1'b0);
    send_value(0, 1'b0);
    send_value(-1, 1'b1);

    // A zero modulus behaves like one.
    wait_drained();
    write_reg(ModulusAddr, 32'd0);
    send_value(5, 1'b0);
    send_value(-5, 1'b1);

    // An oversized modulus clamps to the histogram size.
    wait_drained();
    write_reg(ModulusAddr, 32'd2047);
    send_value(32'sh80000000, 1'b0);
    send_value(32'sh7fffffff, 1'b0);
    send_value(1, 1'b0);
    send_value(1023, 1'b0);
    send_value(-1024, 1'b1);

    // A write to an unmapped register must leave the modulus alone.
    wait_drained();
    write_reg(UnmappedAddr, 32'hffff_ffff);
    write_reg(ModulusAddr, 32'd7);
    send_value(-7, 1'b0);
    send_value(3, 1'b0);
    send_value(4, 1'b0);
    send_value(-3, 1'b0);

    // Changing the modulus in the middle of a sequence rereduces the residue.
    wait_drained();
    write_reg(ModulusAddr, 32'd5);
    send_value(2, 1'b0);
    send_value(3, 1'b1);

    wait_drained();
    write_reg(ModulusAddr, 32'd1024);
    send_value(1024, 1'b0);
    send_value(-1, 1'b1);

    wait_drained();
    write_reg(ModulusAddr, 32'd1025);
    send_value(2047, 1'b1);

    // Random phases, each with its own modulus; sequences may span phases.
    while (items_sent < ItemTarget) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: mod_word = 32'd0;
        1: mod_word = 32'd1;
        2: mod_word = $urandom_range(2, 4);
        3, 4: mod_word = $urandom_range(2, 16);
        5: mod_word = $urandom_range(17, 128);
        6: mod_word = $urandom_range(129, 1023);
        7: mod_word = 32'd1024;
        8: mod_word = $urandom_range(1025, 2047);
        default: mod_word = ($urandom & ~32'h7ff) | $urandom_range(2, 16);
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(UnmappedAddr, $urandom);
      write_reg(ModulusAddr, mod_word);

      // The tail of the run and some phases go without any idling.
      idle_mode = (items_sent < ItemTarget * 17 / 20) && ($urandom_range(0, 3) != 0);
      gaps_on = idle_mode;
      stalls_on = idle_mode;

      repeat ($urandom_range(8, 48)) begin
        if (seq_left == 0)
          seq_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        case ($urandom_range(0, 7))
          0, 1, 2: v = $urandom;
          3: v = int'($urandom_range(0, 64)) - 32;
          4: v = cur_mod * int'($urandom_range(0, 4000)) * ($urandom_range(0, 1) ? 1 : -1);
          5: begin
            case ($urandom_range(0, 3))
              0: v = 32'sh80000000;
              1: v = 32'sh7fffffff;
              2: v = 0;
              default: v = -1;
            endcase
          end
          default: v = int'($urandom_range(0, 2 * cur_mod)) - cur_mod;
        endcase
        send_value(v, seq_left == 1);
        seq_left--;
      end
    end

    wait_drained();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sdc_pkg.sv
rtl/sdc_mod_unit.sv
rtl/sdc_hist_ram.sv
rtl/subarray_sum_divisible_counter.sv
rtl/sdc_checker.sv
sim/subarray_sum_divisible_checker.sv
sim/tb_subarray_sum_divisible_counter.sv
